>>> rtl/ohlc_pkg.sv
// Shared types and constants for the OHLC bar builder.
// Holds the item structs, bar accumulator struct, sequencer states and divider request.
// Depends on nothing; every other file imports it.
package ohlc_pkg;

    // Field widths of the item fields and the bar accumulators.
    localparam int TIME_W   = 64;
    localparam int PRICE_W  = 32;
    localparam int AMOUNT_W = 32;
    localparam int PERIOD_W = 40;
    localparam int VOL_W    = 64;
    localparam int CNT_W    = 32;
    localparam int TOTAL_W  = 64;

    // Bar period after reset, in timestamp units.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(60000000);

    // Operation codes of an input item.
    localparam logic OP_TRADE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // One input item.
    typedef struct packed {
        logic               operation;
        logic [TIME_W-1:0]  trade_time;
        logic               is_buy;
        logic [PRICE_W-1:0] trade_price;
        logic [AMOUNT_W-1:0] trade_amount;
    } trade_t;

    // One result item.
    typedef struct packed {
        logic [TIME_W-1:0]  bar_start_time;
        logic [PRICE_W-1:0] open_tick;
        logic [PRICE_W-1:0] high_tick;
        logic [PRICE_W-1:0] low_tick;
        logic [PRICE_W-1:0] close_tick;
        logic [PRICE_W-1:0] buy_mean_tick;
        logic [PRICE_W-1:0] sell_mean_tick;
        logic [VOL_W-1:0]   buy_volume;
        logic [VOL_W-1:0]   sell_volume;
        logic [CNT_W-1:0]   buy_trades;
        logic [CNT_W-1:0]   sell_trades;
    } bar_t;

    // Running contents of one bar.
    typedef struct packed {
        logic [TIME_W-1:0]  start;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [VOL_W-1:0]   buy_vol;
        logic [VOL_W-1:0]   sell_vol;
        logic [CNT_W-1:0]   buy_cnt;
        logic [CNT_W-1:0]   sell_cnt;
        logic [TOTAL_W-1:0] buy_total;
        logic [TOTAL_W-1:0] sell_total;
    } bar_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUY_START,
        ST_BUY_WAIT,
        ST_SELL_START,
        ST_SELL_WAIT,
        ST_LOAD
    } seq_state_t;

endpackage

>>> rtl/ohlc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Divides a price total by a trade count for the bar averages.
// Depends on ohlc_pkg.
module ohlc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ohlc_pkg::div_req_t req,
    output logic              done,
    output logic [ohlc_pkg::TOTAL_W-1:0] quotient
);
    import ohlc_pkg::*;

    localparam int STEP_W = $clog2(TOTAL_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W:0]      rem_reg;
    logic [TOTAL_W-1:0]  quot_reg;
    logic [CNT_W-1:0]    divisor_reg;

    logic [CNT_W:0]      rem_shift;
    logic [CNT_W+1:0]    trial;
    logic                fits;

    // Shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        rem_shift = {rem_reg[CNT_W-1:0], quot_reg[TOTAL_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};
        fits      = !trial[CNT_W+1];
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quot_reg    <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[CNT_W:0] : rem_shift;
            quot_reg <= {quot_reg[TOTAL_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/trade_stream_ohlc_bar_builder_unit.sv
// OHLC bar builder: a trade that stays within the open bar is taken without stalling the input.
// An item that closes a bar stalls the input until its result is loaded, waiting on the
// shared 64-step divider running once per side; a side without trades skips it.
// The next item is taken while a finished result still waits on the output register.
// Reset (rst_n, asynchronous, active low) leaves no bar open and the bar period at 60000000.
// Depends on ohlc_pkg and ohlc_div.
module trade_stream_ohlc_bar_builder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [ohlc_pkg::PERIOD_W-1:0]   cfg_write_data,
    input  logic                            trade_valid,
    output logic                            trade_stall,
    input  ohlc_pkg::trade_t                trade,
    output logic                            bar_valid,
    input  logic                            bar_stall,
    output ohlc_pkg::bar_t                  bar
);
    import ohlc_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg;
    logic                active_reg, active_next;
    bar_state_t          acc_reg, acc_next;
    bar_state_t          snap_reg, snap_next;
    logic [PRICE_W-1:0]  avg_buy_reg, avg_sell_reg;
    bar_t                out_reg;
    logic                out_valid_reg;

    logic                accept;
    logic                emit;
    logic                seed;
    logic [TIME_W:0]     end_sum;
    logic [TIME_W-1:0]   bar_end;
    bar_state_t          base;
    logic                out_free;
    div_req_t            div_req;
    logic                div_done;
    logic [TOTAL_W-1:0]  div_quot;
    logic [PRICE_W-1:0]  div_avg;

    // Saturating add of an item field to a 64-bit accumulator.
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [PRICE_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W+1)'(b);
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    // Saturating increment of a trade count.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (a == '1) ? a : a + CNT_W'(1);
    endfunction

    assign accept   = trade_valid && !trade_stall;
    assign out_free = !out_valid_reg || !bar_stall;

    // Bar end, saturating at the top of the time range.
    always_comb
    begin
        end_sum = {1'b0, acc_reg.start} + (TIME_W+1)'(period_reg);
        bar_end = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
    end

    // Bar accumulation: seed a new bar where needed, then add the trade; a flush closes the open bar.
    always_comb
    begin
        active_next = active_reg;
        snap_next   = snap_reg;
        emit        = 1'b0;
        seed        = 1'b0;
        base        = acc_reg;
        acc_next    = acc_reg;
        if (accept)
        begin
            if (trade.operation == OP_FLUSH)
            begin
                if (active_reg)
                begin
                    emit        = 1'b1;
                    snap_next   = acc_reg;
                    active_next = 1'b0;
                end
            end
            else
            begin
                if (!active_reg)
                begin
                    seed = 1'b1;
                end
                else if (trade.trade_time > bar_end)
                begin
                    seed      = 1'b1;
                    emit      = 1'b1;
                    snap_next = acc_reg;
                end
                if (seed)
                begin
                    base       = '0;
                    base.start = active_reg ? bar_end : trade.trade_time;
                    base.open  = trade.trade_price;
                    base.high  = trade.trade_price;
                    base.low   = trade.trade_price;
                end
                active_next = 1'b1;
                acc_next    = base;
                if (trade.trade_price > base.high)
                begin
                    acc_next.high = trade.trade_price;
                end
                if (trade.trade_price < base.low)
                begin
                    acc_next.low = trade.trade_price;
                end
                acc_next.close = trade.trade_price;
                if (trade.is_buy)
                begin
                    acc_next.buy_cnt   = sat_inc(base.buy_cnt);
                    acc_next.buy_total = sat_add(base.buy_total, trade.trade_price);
                    acc_next.buy_vol   = sat_add(base.buy_vol, trade.trade_amount);
                end
                else
                begin
                    acc_next.sell_cnt   = sat_inc(base.sell_cnt);
                    acc_next.sell_total = sat_add(base.sell_total, trade.trade_price);
                    acc_next.sell_vol   = sat_add(base.sell_vol, trade.trade_amount);
                end
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = ST_BUY_START;
                end
            end
            ST_BUY_START:
            begin
                state_next = (snap_reg.buy_cnt == '0) ? ST_SELL_START : ST_BUY_WAIT;
            end
            ST_BUY_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_SELL_START;
                end
            end
            ST_SELL_START:
            begin
                state_next = (snap_reg.sell_cnt == '0) ? ST_LOAD : ST_SELL_WAIT;
            end
            ST_SELL_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input stall and divider requests.
    always_comb
    begin
        trade_stall     = 1'b1;
        div_req.start   = 1'b0;
        div_req.dividend = snap_reg.buy_total;
        div_req.divisor = snap_reg.buy_cnt;
        case (state_reg)
            ST_IDLE:
            begin
                trade_stall = 1'b0;
            end
            ST_BUY_START:
            begin
                div_req.start = (snap_reg.buy_cnt != '0);
            end
            ST_SELL_START:
            begin
                div_req.start    = (snap_reg.sell_cnt != '0);
                div_req.dividend = snap_reg.sell_total;
                div_req.divisor  = snap_reg.sell_cnt;
            end
            default:
            begin
                trade_stall = 1'b1;
            end
        endcase
    end

    // Shared divider for both averages.
    ohlc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // An average above the price range clips to the largest price.
    assign div_avg = (div_quot[TOTAL_W-1:PRICE_W] != '0) ? '1 : div_quot[PRICE_W-1:0];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            if (cfg_write_en)
            begin
                period_reg <= cfg_write_data;
            end
            if (state_reg == ST_LOAD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!bar_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: running bar, closed-bar snapshot, averages and output.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        snap_reg <= snap_next;
        if (state_reg == ST_BUY_START)
        begin
            avg_buy_reg <= '0;
        end
        else if (state_reg == ST_BUY_WAIT && div_done)
        begin
            avg_buy_reg <= div_avg;
        end
        if (state_reg == ST_SELL_START)
        begin
            avg_sell_reg <= '0;
        end
        else if (state_reg == ST_SELL_WAIT && div_done)
        begin
            avg_sell_reg <= div_avg;
        end
        if (state_reg == ST_LOAD && out_free)
        begin
            out_reg.bar_start_time <= snap_reg.start;
            out_reg.open_tick      <= snap_reg.open;
            out_reg.high_tick      <= snap_reg.high;
            out_reg.low_tick       <= snap_reg.low;
            out_reg.close_tick     <= snap_reg.close;
            out_reg.buy_mean_tick  <= avg_buy_reg;
            out_reg.sell_mean_tick <= avg_sell_reg;
            out_reg.buy_volume     <= snap_reg.buy_vol;
            out_reg.sell_volume    <= snap_reg.sell_vol;
            out_reg.buy_trades     <= snap_reg.buy_cnt;
            out_reg.sell_trades    <= snap_reg.sell_cnt;
        end
    end

    assign bar_valid = out_valid_reg;
    assign bar       = out_reg;

endmodule

>>> rtl/ohlc_checker.sv
// Port-level checks for the OHLC bar builder, attached by a bind statement.
// Depends on ohlc_pkg and the top level trade_stream_ohlc_bar_builder_unit.
module ohlc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_write_en,
    input logic [ohlc_pkg::PERIOD_W-1:0] cfg_write_data,
    input logic                          trade_valid,
    input logic                          trade_stall,
    input ohlc_pkg::trade_t              trade,
    input logic                          bar_valid,
    input logic                          bar_stall,
    input ohlc_pkg::bar_t                bar
);
    import ohlc_pkg::*;

    // A result that is held back keeps its contents.
    a_bar_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid && bar_stall |=> bar_valid && $stable(bar))
        else $error("bar item changed while stalled");

    // The input only starts stalling right after an item was taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(trade_stall) |-> $past(trade_valid && !trade_stall))
        else $error("input stall without a preceding item");

    // A new result appears only while the input side is held off.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bar_valid) |-> $past(trade_stall))
        else $error("result appeared while idle");

    // Prices of a bar are ordered and an empty side reports nothing.
    a_bar_sane: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid |-> bar.high_tick >= bar.low_tick
                   && bar.high_tick >= bar.open_tick && bar.low_tick <= bar.close_tick
                   && (bar.buy_trades != '0 || (bar.buy_mean_tick == '0
                       && bar.buy_volume == '0))
                   && (bar.sell_trades != '0 || (bar.sell_mean_tick == '0
                       && bar.sell_volume == '0)))
        else $error("inconsistent bar contents");

endmodule

bind trade_stream_ohlc_bar_builder_unit ohlc_checker u_ohlc_checker (.*);
